// File: sv/imhq_pkg.sv
// Shared types, constants and codes for the indexed min-heap queue.
// No dependencies.
package imhq_pkg;
    localparam int CAPACITY = 1024;
    localparam int NODES = 4096;
    localparam int POS_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ID_W = 12;
    localparam int KEY_W = 32;
    localparam int NODE_AW = $clog2(NODES);
    localparam int ENTRY_W = ID_W + KEY_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_OPEN = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } entry_t;
endpackage

// File: sv/indexed_min_heap_queue_core.sv
// Top level of the indexed min-heap queue: sequencer, heap memories, position
// map and open-mark clearing. Depends on imhq_pkg and imhq_ram.
//
//  channel | ports                                       | direction
//  request | s_valid s_ready s_command s_node_id s_key   | in
//  result  | m_valid m_ready m_out_node_id m_out_key ... | out
//
// An insert climbs toward the root, an update climbs and then descends, an
// extract descends from the root (not when it empties the heap), and a
// rejected request goes straight to the result. After reset a clearing
// pass zeroes the open marks; no request is taken meanwhile. The result
// register holds while m_ready is low; the next request is taken meanwhile
// and waits in its last step until the result register is free.
module indexed_min_heap_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [11:0] s_node_id,
    input  logic [31:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_out_node_id,
    output logic [31:0] m_out_key,
    output logic [1:0]  m_status,
    output logic        m_is_empty,
    output logic [31:0] m_min_key,
    output logic [10:0] m_count
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_UPRD  = 4'd4;
    localparam logic [3:0] S_UPCMP = 4'd5;
    localparam logic [3:0] S_DNL   = 4'd6;
    localparam logic [3:0] S_DNR   = 4'd7;
    localparam logic [3:0] S_DNCMP = 4'd8;
    localparam logic [3:0] S_ROOT  = 4'd9;
    localparam logic [3:0] S_ROOTW = 4'd10;
    localparam logic [3:0] S_LAST  = 4'd11;
    localparam logic [3:0] S_LASTW = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] state_reg;
    logic [imhq_pkg::NODE_AW-1:0] clr_reg;
    logic [imhq_pkg::CNT_W-1:0] cnt_reg;
    logic [1:0] cmd_reg;
    logic [imhq_pkg::ID_W-1:0] id_reg;
    logic [imhq_pkg::KEY_W-1:0] key_reg;
    logic [imhq_pkg::POS_W-1:0] pos_reg;
    logic [imhq_pkg::POS_W-1:0] best_pos_reg;
    imhq_pkg::entry_t best_reg;
    logic [imhq_pkg::ID_W-1:0] rid_reg;
    logic [imhq_pkg::KEY_W-1:0] rkey_reg;
    logic [imhq_pkg::KEY_W-1:0] root_key_reg;
    logic root_fwd_reg;
    logic [1:0] status_reg;
    logic down_only_reg;

    logic h_we;
    logic [imhq_pkg::POS_W-1:0] h_waddr, h_raddr;
    imhq_pkg::entry_t h_wdata, h_rdata;
    logic p_we;
    logic [imhq_pkg::NODE_AW-1:0] p_waddr, p_raddr;
    logic [imhq_pkg::POS_W-1:0] p_wdata, p_rdata;
    logic o_we;
    logic [imhq_pkg::NODE_AW-1:0] o_waddr;
    logic o_wdata, o_rdata;
    logic h_we2;
    logic [imhq_pkg::POS_W-1:0] h_waddr2;
    imhq_pkg::entry_t h_wdata2;
    logic p_we2;
    logic [imhq_pkg::NODE_AW-1:0] p_waddr2;
    logic [imhq_pkg::POS_W-1:0] p_wdata2;

    imhq_ram #(.WIDTH(imhq_pkg::ENTRY_W), .DEPTH(imhq_pkg::CAPACITY)) u_heap (
        .aclk(aclk), .we(h_we | h_we2), .waddr(h_we ? h_waddr : h_waddr2),
        .wdata(h_we ? h_wdata : h_wdata2), .raddr(h_raddr), .rdata(h_rdata));
    imhq_ram #(.WIDTH(imhq_pkg::POS_W), .DEPTH(imhq_pkg::NODES)) u_pos (
        .aclk(aclk), .we(p_we | p_we2), .waddr(p_we ? p_waddr : p_waddr2),
        .wdata(p_we ? p_wdata : p_wdata2), .raddr(p_raddr), .rdata(p_rdata));
    imhq_ram #(.WIDTH(1), .DEPTH(imhq_pkg::NODES)) u_open (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(p_raddr), .rdata(o_rdata));

    // Second write port is realized as a following cycle: pending swap half.
    logic pend_reg;
    imhq_pkg::entry_t pend_e_reg;
    logic [imhq_pkg::POS_W-1:0] pend_pos_reg;

    logic [imhq_pkg::POS_W-1:0] parent_pos, left_pos, right_pos;
    logic [imhq_pkg::POS_W:0] left_w;
    logic [imhq_pkg::POS_W+1:0] right_w;
    logic left_ok, right_ok, id_ok;
    logic accept;
    logic res_free;
    logic dn_right;
    logic [imhq_pkg::POS_W-1:0] dn_pos;
    imhq_pkg::entry_t dn_e;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign res_free = !m_valid || m_ready;
    assign parent_pos = (pos_reg - 1'b1) >> 1;
    assign left_w = {pos_reg, 1'b1};
    assign right_w = {1'b0, pos_reg, 1'b0} + 12'd2;
    assign left_pos = left_w[imhq_pkg::POS_W-1:0];
    assign right_pos = right_w[imhq_pkg::POS_W-1:0];
    assign left_ok = {1'b0, left_w} < {1'b0, cnt_reg};
    assign right_ok = right_w < {1'b0, cnt_reg};
    assign id_ok = ({1'b0, s_node_id} < 13'(imhq_pkg::NODES));
    assign dn_right = right_ok && h_rdata.key < best_reg.key;
    assign dn_pos = dn_right ? right_pos : best_pos_reg;
    assign dn_e = dn_right ? h_rdata : best_reg;

    // Write of the pending half of a swap takes the write port in the following cycle.
    assign h_we2 = pend_reg;
    assign h_waddr2 = pend_pos_reg;
    assign h_wdata2 = pend_e_reg;
    assign p_we2 = pend_reg;
    assign p_waddr2 = pend_e_reg.id[imhq_pkg::NODE_AW-1:0];
    assign p_wdata2 = pend_pos_reg;

    always_comb begin
        h_we = 1'b0; h_waddr = pos_reg; h_wdata = best_reg; h_raddr = pos_reg;
        p_we = 1'b0; p_waddr = id_reg[imhq_pkg::NODE_AW-1:0]; p_wdata = pos_reg;
        p_raddr = id_reg[imhq_pkg::NODE_AW-1:0];
        o_we = 1'b0; o_waddr = id_reg[imhq_pkg::NODE_AW-1:0]; o_wdata = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                o_we = 1'b1; o_waddr = clr_reg;
            end
            S_IDLE: p_raddr = s_node_id[imhq_pkg::NODE_AW-1:0];
            S_UPRD: h_raddr = parent_pos;
            S_UPCMP: begin
                if (pos_reg != '0 && key_reg < h_rdata.key) begin
                    h_we = 1'b1; h_waddr = pos_reg; h_wdata = h_rdata;
                    p_we = 1'b1; p_waddr = h_rdata.id[imhq_pkg::NODE_AW-1:0];
                    p_wdata = pos_reg;
                end
            end
            S_DNL: h_raddr = left_pos;
            S_DNR: h_raddr = right_pos;
            S_DNCMP: begin
                if (dn_pos != pos_reg) begin
                    h_we = 1'b1; h_waddr = pos_reg; h_wdata = dn_e;
                    p_we = 1'b1; p_waddr = dn_e.id[imhq_pkg::NODE_AW-1:0];
                    p_wdata = pos_reg;
                end
            end
            S_ROOT: h_raddr = '0;
            S_LAST: h_raddr = cnt_reg[imhq_pkg::POS_W-1:0];
            S_LASTW: begin
                o_we = 1'b1; o_waddr = rid_reg[imhq_pkg::NODE_AW-1:0];
            end
            S_DONE: h_raddr = '0;
            S_DEC: h_raddr = '0;
            S_LOOK: begin
                if (cmd_reg == imhq_pkg::CMD_INSERT && !o_rdata
                    && cnt_reg < imhq_pkg::CNT_W'(imhq_pkg::CAPACITY)) begin
                    o_we = 1'b1; o_wdata = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
            m_valid <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= 1'b0;
            if (state_reg == S_DEC && res_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == imhq_pkg::NODE_AW'(imhq_pkg::NODES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        cmd_reg <= s_command;
                        id_reg <= s_node_id;
                        key_reg <= s_key;
                        rid_reg <= '0;
                        rkey_reg <= '0;
                        down_only_reg <= 1'b0;
                        status_reg <= imhq_pkg::ST_OK;
                        if (s_command == imhq_pkg::CMD_EXTRACT) begin
                            if (cnt_reg == '0) begin
                                status_reg <= imhq_pkg::ST_EMPTY;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_ROOT;
                            end
                        end else if (s_command == imhq_pkg::CMD_NOP) begin
                            state_reg <= S_DONE;
                        end else if (!id_ok) begin
                            status_reg <= imhq_pkg::ST_NOT_OPEN;
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    if (o_rdata) begin
                        pos_reg <= p_rdata;
                        if ({1'b0, p_rdata} < cnt_reg) begin
                            state_reg <= S_UPRD;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else if (cmd_reg == imhq_pkg::CMD_UPDATE) begin
                        status_reg <= imhq_pkg::ST_NOT_OPEN;
                        state_reg <= S_DONE;
                    end else if (cnt_reg >= imhq_pkg::CNT_W'(imhq_pkg::CAPACITY)) begin
                        status_reg <= imhq_pkg::ST_FULL;
                        state_reg <= S_DONE;
                    end else begin
                        pos_reg <= cnt_reg[imhq_pkg::POS_W-1:0];
                        cnt_reg <= cnt_reg + 1'b1;
                        down_only_reg <= 1'b1;
                        state_reg <= S_UPRD;
                    end
                end
                S_UPRD: state_reg <= S_UPCMP;
                S_UPCMP: begin
                    if (pos_reg != '0 && key_reg < h_rdata.key) begin
                        pos_reg <= parent_pos;
                        state_reg <= S_UPRD;
                    end else begin
                        pend_reg <= 1'b1;
                        pend_pos_reg <= pos_reg;
                        pend_e_reg <= '{id: id_reg, key: key_reg};
                        state_reg <= down_only_reg ? S_DONE : S_DNL;
                    end
                end
                S_DNL: begin
                    best_pos_reg <= pos_reg;
                    best_reg <= '{id: id_reg, key: key_reg};
                    state_reg <= S_DNR;
                end
                S_DNR: begin
                    if (left_ok && h_rdata.key < best_reg.key) begin
                        best_pos_reg <= left_pos;
                        best_reg <= h_rdata;
                    end
                    state_reg <= S_DNCMP;
                end
                S_DNCMP: begin
                    if (dn_pos != pos_reg) begin
                        pos_reg <= dn_pos;
                        state_reg <= S_DNL;
                    end else begin
                        pend_reg <= 1'b1;
                        pend_pos_reg <= pos_reg;
                        pend_e_reg <= '{id: id_reg, key: key_reg};
                        state_reg <= S_DONE;
                    end
                end
                S_ROOT: state_reg <= S_ROOTW;
                S_ROOTW: begin
                    rid_reg <= h_rdata.id;
                    rkey_reg <= h_rdata.key;
                    cnt_reg <= cnt_reg - 1'b1;
                    state_reg <= S_LAST;
                end
                S_LAST: state_reg <= S_LASTW;
                S_LASTW: begin
                    id_reg <= h_rdata.id;
                    key_reg <= h_rdata.key;
                    pos_reg <= '0;
                    state_reg <= (cnt_reg == '0) ? S_DONE : S_DNL;
                end
                S_DONE: begin
                    root_fwd_reg <= pend_reg && (pend_pos_reg == '0);
                    root_key_reg <= pend_e_reg.key;
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (res_free) begin
                        m_out_node_id <= rid_reg;
                        m_out_key <= rkey_reg;
                        m_status <= status_reg;
                        m_is_empty <= (cnt_reg == '0);
                        m_min_key <= (cnt_reg == '0) ? '1 :
                                     (root_fwd_reg ? root_key_reg : h_rdata.key);
                        m_count <= cnt_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_out_node_id, m_out_key, m_status,
                                         m_is_empty, m_min_key, m_count}))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_count == '0)))
        else $error("empty flag disagrees with count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= imhq_pkg::CNT_W'(imhq_pkg::CAPACITY))
        else $error("entry count beyond capacity");
endmodule

// File: sv/imhq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
